// ===== src/mca_pkg.sv =====
// ----------------------------------------------------------------------------
// mca_pkg: shared constants for the mosaic cell average block
// Widths of fields, totals and counters, and register indexes and resets.
// ----------------------------------------------------------------------------
package mca_pkg;

   localparam int DEF_MAX_WIDTH     = 4096;
   localparam int DEF_MAX_CELL_LOG2 = 7;
   localparam int ROW_LIMIT         = 4096;

   localparam int PIX_W   = 8;
   localparam int POS_W   = 12;
   localparam int SIZE_W  = 13;
   localparam int LOG_W   = 3;
   localparam int TOTAL_W = 32;
   localparam int CNT_W   = 25;

   localparam int CSR_ADDR_W = 2;
   localparam logic [CSR_ADDR_W-1:0] CSR_IMAGE_WIDTH  = 2'd0;
   localparam logic [CSR_ADDR_W-1:0] CSR_IMAGE_HEIGHT = 2'd1;
   localparam logic [CSR_ADDR_W-1:0] CSR_CELL_LOG2    = 2'd2;

   localparam logic [SIZE_W-1:0] RST_IMAGE_WIDTH  = 13'd64;
   localparam logic [SIZE_W-1:0] RST_IMAGE_HEIGHT = 13'd64;
   localparam logic [LOG_W-1:0]  RST_CELL_LOG2    = 3'd6;

   localparam logic KIND_CELL  = 1'b0;
   localparam logic KIND_IMAGE = 1'b1;

endpackage

// ===== src/mca_sum_ram.sv =====
// ----------------------------------------------------------------------------
// mca_sum_ram: per cell column RGB sum memory
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module mca_sum_ram
   import mca_pkg::*;
#(
   parameter int DEPTH = DEF_MAX_WIDTH,
   parameter int DW    = 3 * PIX_W,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr,
   output logic [DW-1:0] rd_data,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [DW-1:0] wr_data
);

   logic [DW-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

// ===== src/mca_div.sv =====
// ----------------------------------------------------------------------------
// mca_div: three lane restoring divider
// Divides three dividends by one divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mca_div
   import mca_pkg::*;
(
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic [2:0][TOTAL_W-1:0]     dividend,
   input  logic [CNT_W-1:0]            divisor,
   output logic                        done,
   output logic [2:0][TOTAL_W-1:0]     quotient
);

   localparam int STEP_W = $clog2(TOTAL_W + 1);

   logic                    busy_ff, busy_in;
   logic [STEP_W-1:0]       step_ff, step_in;
   logic                    done_ff, done_in;
   logic [CNT_W-1:0]        den_ff, den_in;
   logic [2:0][TOTAL_W-1:0] dvd_ff, dvd_in;
   logic [2:0][TOTAL_W-1:0] quo_ff, quo_in;
   logic [2:0][CNT_W:0]     rem_ff, rem_in;
   logic [CNT_W+1:0]        trial;

   always_comb begin
      busy_in = busy_ff;
      step_in = step_ff;
      done_in = 1'b0;
      den_in  = den_ff;
      dvd_in  = dvd_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      trial   = '0;
      if (start) begin
         busy_in = 1'b1;
         step_in = '0;
         den_in  = divisor;
         dvd_in  = dividend;
         quo_in  = '0;
         rem_in  = '0;
      end else if (busy_ff) begin
         for (int k = 0; k < 3; k++) begin
            trial = {rem_ff[k], dvd_ff[k][TOTAL_W-1]};
            if (trial >= {2'b00, den_ff}) begin
               trial = trial - {2'b00, den_ff};
               quo_in[k] = {quo_ff[k][TOTAL_W-2:0], 1'b1};
            end else begin
               quo_in[k] = {quo_ff[k][TOTAL_W-2:0], 1'b0};
            end
            rem_in[k] = trial[CNT_W:0];
            dvd_in[k] = {dvd_ff[k][TOTAL_W-2:0], 1'b0};
         end
         step_in = step_ff + 1'b1;
         if (step_ff == STEP_W'(TOTAL_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      den_ff <= den_in;
      dvd_ff <= dvd_in;
      quo_ff <= quo_in;
      rem_ff <= rem_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ===== src/mosaic_cell_average_top.sv =====
// ----------------------------------------------------------------------------
// mosaic_cell_average_top: block average mosaic statistics engine
// Sums RGB pixels per cell, emits cell averages and the image average.
// ----------------------------------------------------------------------------
// One pixel is taken at a time. A pixel that does not finish a cell goes
// through accept with memory read, then sum and write back. A pixel that
// finishes a cell then also passes through the shared serial divider and the
// output transfer; the image's final pixel adds a second divide and transfer
// for the image average.
// ----------------------------------------------------------------------------
module mosaic_cell_average_top
   import mca_pkg::*;
#(
   parameter int MAX_WIDTH     = DEF_MAX_WIDTH,
   parameter int MAX_CELL_LOG2 = DEF_MAX_CELL_LOG2
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [23:0]           req_tdata,   // red_in, green_in, blue_in
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [47:0]           rsp_tdata,   // cell_col, cell_row, red_avg, green_avg, blue_avg
   output logic                  rsp_tuser,   // result_kind
   output logic                  rsp_tlast,   // last_of_run
   input  logic                  csr_wr_en,
   input  logic [CSR_ADDR_W-1:0] csr_addr,
   input  logic [SIZE_W-1:0]     csr_wdata
);

   localparam int CW    = $clog2(MAX_WIDTH);
   localparam int WW    = $clog2(MAX_WIDTH + 1);
   localparam int LGW   = $clog2(MAX_CELL_LOG2 + 1);
   localparam int SW    = MAX_CELL_LOG2 + 1;
   localparam int SUM_W = PIX_W + 2 * MAX_CELL_LOG2;

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_READ    = 3'd1;
   localparam logic [2:0] S_DIV     = 3'd2;
   localparam logic [2:0] S_OUT     = 3'd3;
   localparam logic [2:0] S_DIV_IMG = 3'd4;
   localparam logic [2:0] S_OUT_IMG = 3'd5;

   logic [2:0]        state_ff, state_in;
   logic [SIZE_W-1:0] width_ff, height_ff;
   logic [LOG_W-1:0]  log2_ff;
   logic [CW-1:0]     col_ff, col_nx_ff;
   logic [POS_W-1:0]  row_ff, row_nx_ff;
   logic [CW-1:0]     idx_ff;
   logic [POS_W-1:0]  cx_ff, cy_ff;
   logic              first_ff, cdone_ff, idone_ff;
   logic [CNT_W-1:0]  npix_ff;
   logic [23:0]       pix_ff;
   logic [2:0][TOTAL_W-1:0] tot_ff;
   logic [CNT_W-1:0]  count_ff;
   logic              kind_ff, last_ff;
   logic [POS_W-1:0]  ocol_ff, orow_ff;
   logic [2:0][PIX_W-1:0] avg_ff;

   logic [WW-1:0]     w;
   logic [SIZE_W-1:0] h;
   logic [LGW-1:0]    lg;
   logic [SW-1:0]     side, cell_w, cell_h;
   logic [CW-1:0]     col_e, cx, cx_base, col_nx;
   logic [POS_W-1:0]  row_e, cy, cy_base, row_nx;
   logic [WW-1:0]     cell_w_full;
   logic [SIZE_W-1:0] cell_h_full;
   logic              first, cdone, idone;

   logic                    accept, restart;
   logic [3*SUM_W-1:0]      rd_data, wr_data;
   logic [2:0][SUM_W-1:0]   new_sum;
   logic                    div_start, div_done;
   logic [2:0][TOTAL_W-1:0] div_dvd, div_quo;
   logic [CNT_W-1:0]        div_den;

   always_comb begin
      if (width_ff == '0) w = WW'(1);
      else if (32'(width_ff) > 32'(MAX_WIDTH)) w = WW'(MAX_WIDTH);
      else w = WW'(width_ff);
      if (height_ff == '0) h = SIZE_W'(1);
      else if (32'(height_ff) > 32'(ROW_LIMIT)) h = SIZE_W'(ROW_LIMIT);
      else h = height_ff;
      if (32'(log2_ff) > 32'(MAX_CELL_LOG2)) lg = LGW'(MAX_CELL_LOG2);
      else lg = LGW'(log2_ff);
      side  = SW'(1) << lg;
      col_e = (32'(col_ff) >= 32'(w)) ? '0 : col_ff;
      row_e = (32'(row_ff) >= 32'(h)) ? '0 : row_ff;
      cx      = col_e >> lg;
      cy      = row_e >> lg;
      cx_base = cx << lg;
      cy_base = cy << lg;
      cell_w_full = w - WW'(cx_base);
      cell_h_full = h - SIZE_W'(cy_base);
      cell_w = (32'(cell_w_full) > 32'(side)) ? side : SW'(cell_w_full);
      cell_h = (32'(cell_h_full) > 32'(side)) ? side : SW'(cell_h_full);
      first = ((32'(col_e) & (32'(side) - 32'd1)) == 32'd0) &&
              ((32'(row_e) & (32'(side) - 32'd1)) == 32'd0);
      cdone = (32'(col_e) == 32'(cx_base) + 32'(cell_w) - 32'd1) &&
              (32'(row_e) == 32'(cy_base) + 32'(cell_h) - 32'd1);
      idone = (32'(col_e) == 32'(w) - 32'd1) && (32'(row_e) == 32'(h) - 32'd1);
      if (32'(col_e) + 32'd1 >= 32'(w)) begin
         col_nx = '0;
         row_nx = (32'(row_e) + 32'd1 >= 32'(h)) ? '0 : row_e + 1'b1;
      end else begin
         col_nx = col_e + 1'b1;
         row_nx = row_e;
      end
   end

   assign accept = req_tvalid && req_tready;
   assign req_tready = (state_ff == S_IDLE);

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         new_sum[k] = (first_ff ? '0 : rd_data[k*SUM_W +: SUM_W]) +
                      SUM_W'(pix_ff[k*PIX_W +: PIX_W]);
      end
   end
   assign wr_data = new_sum;

   mca_sum_ram #(
      .DEPTH (MAX_WIDTH),
      .DW    (3 * SUM_W),
      .AW    (CW)
   ) u_ram (
      .clock   (clock),
      .rd_en   (accept),
      .rd_addr (cx),
      .rd_data (rd_data),
      .wr_en   (state_ff == S_READ),
      .wr_addr (idx_ff),
      .wr_data (wr_data)
   );

   always_comb begin
      div_start = 1'b0;
      div_dvd   = tot_ff;
      div_den   = (count_ff == '0) ? CNT_W'(1) : count_ff;
      state_in  = state_ff;
      restart   = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) state_in = S_READ;
            if (csr_wr_en && (csr_addr == CSR_IMAGE_WIDTH ||
                csr_addr == CSR_IMAGE_HEIGHT || csr_addr == CSR_CELL_LOG2)) begin
               restart = 1'b1;
            end
         end
         S_READ: begin
            if (cdone_ff) begin
               div_start = 1'b1;
               for (int k = 0; k < 3; k++) div_dvd[k] = TOTAL_W'(new_sum[k]);
               div_den  = npix_ff;
               state_in = S_DIV;
            end else if (idone_ff) begin
               div_start = 1'b1;
               state_in  = S_DIV_IMG;
            end else begin
               state_in = S_IDLE;
            end
         end
         S_DIV: begin
            if (div_done) state_in = S_OUT;
         end
         S_OUT: begin
            if (rsp_tready) begin
               if (idone_ff) begin
                  div_start = 1'b1;
                  state_in  = S_DIV_IMG;
               end else begin
                  state_in = S_IDLE;
               end
            end
         end
         S_DIV_IMG: begin
            if (div_done) state_in = S_OUT_IMG;
         end
         S_OUT_IMG: begin
            if (rsp_tready) begin
               restart  = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   mca_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dvd),
      .divisor  (div_den),
      .done     (div_done),
      .quotient (div_quo)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         width_ff  <= RST_IMAGE_WIDTH;
         height_ff <= RST_IMAGE_HEIGHT;
         log2_ff   <= RST_CELL_LOG2;
         col_ff    <= '0;
         row_ff    <= '0;
         tot_ff    <= '0;
         count_ff  <= '0;
      end else begin
         state_ff <= state_in;
         if (csr_wr_en) begin
            unique case (csr_addr)
               CSR_IMAGE_WIDTH:  width_ff  <= csr_wdata;
               CSR_IMAGE_HEIGHT: height_ff <= csr_wdata;
               CSR_CELL_LOG2:    log2_ff   <= csr_wdata[LOG_W-1:0];
               default: ;
            endcase
         end
         if (state_ff == S_DIV && div_done) begin
            for (int k = 0; k < 3; k++) tot_ff[k] <= tot_ff[k] + div_quo[k];
            count_ff <= count_ff + 1'b1;
         end
         if ((state_ff == S_READ && !cdone_ff && !idone_ff) ||
             (state_ff == S_OUT && rsp_tready && !idone_ff)) begin
            col_ff <= col_nx_ff;
            row_ff <= row_nx_ff;
         end
         if (restart) begin
            col_ff   <= '0;
            row_ff   <= '0;
            tot_ff   <= '0;
            count_ff <= '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         idx_ff    <= cx;
         cx_ff     <= POS_W'(cx);
         cy_ff     <= cy;
         first_ff  <= first;
         cdone_ff  <= cdone;
         idone_ff  <= idone;
         npix_ff   <= CNT_W'(cell_w) * CNT_W'(cell_h);
         pix_ff    <= req_tdata;
         col_nx_ff <= col_nx;
         row_nx_ff <= row_nx;
      end
      if (div_done) begin
         for (int k = 0; k < 3; k++) avg_ff[k] <= div_quo[k][PIX_W-1:0];
         if (state_ff == S_DIV) begin
            kind_ff <= KIND_CELL;
            ocol_ff <= cx_ff;
            orow_ff <= cy_ff;
            last_ff <= !idone_ff;
         end else begin
            kind_ff <= KIND_IMAGE;
            ocol_ff <= '0;
            orow_ff <= '0;
            last_ff <= 1'b1;
         end
      end
   end

   assign rsp_tvalid = (state_ff == S_OUT) || (state_ff == S_OUT_IMG);
   assign rsp_tdata  = {avg_ff[2], avg_ff[1], avg_ff[0], orow_ff, ocol_ff};
   assign rsp_tuser  = kind_ff;
   assign rsp_tlast  = last_ff;

endmodule
